// File: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with reset disable
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent on the same edge
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/core/tsbc_pkg.sv
// types and constants of the segmented block cache controller
// no dependencies
package tsbc_pkg;

  localparam int NSLOT  = 128;
  localparam int SLOT_W = 7;
  localparam int CNT_W  = 8;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic SEG_PROT = 1'b0;
  localparam logic SEG_PROB = 1'b1;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_PROT = 2'd1;
  localparam logic [1:0] HIT_PROB = 2'd2;

  localparam logic CFG_WRITE_THROUGH = 1'b0;
  localparam logic CFG_BYPASS        = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_SCAN, ST_DECIDE, ST_UNL_RD, ST_UNL_WR,
    ST_FILL, ST_APP1, ST_APP2, ST_CHK, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_HPROT, OP_HPROB, OP_MISS
  } req_op_t;

  typedef enum logic [2:0] {
    LOP_NONE, LOP_RD, LOP_UNLINK, LOP_APP1, LOP_APP2
  } list_op_t;

  typedef struct packed {
    list_op_t            op;
    logic [SLOT_W-1:0]   slot;
    logic                seg;
  } list_cmd_t;

  typedef struct packed {
    logic [1:0][SLOT_W-1:0] head;
    logic [1:0][CNT_W-1:0]  cnt;
  } list_sts_t;

endpackage

// File: rtl/core/tsbc_if.sv
// request and result channel interfaces (valid/ready)
// depends on nothing
interface tsbc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] block_addr;
  modport source (output valid, cmd, block_addr, input ready);
  modport sink   (input valid, cmd, block_addr, output ready);
endinterface

interface tsbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  hit_level;
  logic [6:0]  slot;
  logic        fetch_needed;
  logic        write_now;
  logic        evict_valid;
  logic [31:0] evict_addr;
  logic        evict_writeback;
  modport source (output valid, hit_level, slot, fetch_needed, write_now, evict_valid,
                  evict_addr, evict_writeback, input ready);
  modport sink   (input valid, hit_level, slot, fetch_needed, write_now, evict_valid,
                  evict_addr, evict_writeback, output ready);
endinterface

// File: rtl/core/tsbc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tsbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/tsbc_lists.sv
// doubly linked lists of the two segments: head, tail, count and link rams
// depends on tsbc_pkg and tsbc_ram
module tsbc_lists import tsbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  list_cmd_t cmd,
  output list_sts_t sts
);
  logic [1:0][SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [1:0][CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              nx_we, pv_we;
  logic [SLOT_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd, nx_rd, pv_rd;

  tsbc_ram #(.WIDTH(SLOT_W), .DEPTH(NSLOT)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(cmd.slot), .rdata(nx_rd)
  );
  tsbc_ram #(.WIDTH(SLOT_W), .DEPTH(NSLOT)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(cmd.slot), .rdata(pv_rd)
  );

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    nx_we = 1'b0; nx_wa = cmd.slot; nx_wd = cmd.slot;
    pv_we = 1'b0; pv_wa = cmd.slot; pv_wd = cmd.slot;
    case (cmd.op)
      LOP_UNLINK: begin
        // link data was read in the previous cycle
        if (cnt_r[cmd.seg] != '0) begin
          if (head_r[cmd.seg] == cmd.slot) begin
            head_nxt[cmd.seg] = nx_rd;
          end else begin
            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
          end
          if (tail_r[cmd.seg] == cmd.slot) begin
            tail_nxt[cmd.seg] = pv_rd;
          end else begin
            pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
          end
          cnt_nxt[cmd.seg] = cnt_r[cmd.seg] - CNT_W'(1);
        end
      end
      LOP_APP1: begin
        pv_we = 1'b1;
        if (cnt_r[cmd.seg] == '0) begin
          head_nxt[cmd.seg] = cmd.slot;
          pv_wd = cmd.slot;
        end else begin
          pv_wd = tail_r[cmd.seg];
          nx_we = 1'b1; nx_wa = tail_r[cmd.seg]; nx_wd = cmd.slot;
        end
      end
      LOP_APP2: begin
        nx_we = 1'b1;
        tail_nxt[cmd.seg] = cmd.slot;
        cnt_nxt[cmd.seg]  = cnt_r[cmd.seg] + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign sts.head = head_r;
  assign sts.cnt  = cnt_r;
endmodule

// File: rtl/core/two_segment_block_cache_policy.sv
// Segmented LRU tag and replacement controller for a 128-slot block cache. One request is
// taken at a time: a tag scan reads the entry ram one slot per cycle (up to all 128 slots,
// stopping at the first hit), then the list updates follow (unlink, append and at most one
// eviction); a bypass request skips both the tag scan and the list updates.
// After reset the entry ram is cleared in a pass over all 128 slots, during which no request
// is taken. The result sits in an output register, so the next request may enter while it
// waits. Configuration is written through cfg_we/cfg_idx/cfg_data; the user must write it
// only while no request is in flight, as the block itself does not enforce this.
// Depends on tsbc_pkg, tsbc_if, tsbc_ram and tsbc_lists.
module two_segment_block_cache_policy import tsbc_pkg::*; #(
  parameter int PROTECTED_CAP = 64,
  parameter int PROBATION_CAP = 64,
  parameter int ADDR_BITS     = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic       cfg_data,
  tsbc_in_if.sink    in_if,
  tsbc_out_if.source out_if
);
  localparam int TAG_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [10:0] PROT_CAP_V = 11'(PROTECTED_CAP);
  localparam logic [10:0] PROB_CAP_V = 11'(PROBATION_CAP);

  state_t state_r, state_nxt;
  req_op_t op_r;
  logic wt_r, bypass_r;
  logic cmd_r, byp_r, hit_r, free_found_r, evicting_r, ap_seg_r;
  logic hit_seg_r, hit_dirty_r;
  logic [TAG_W-1:0] addr_r;
  logic [SLOT_W-1:0] s_r, u_r, fs_r, cmp_idx_r, clr_r;
  logic [SLOT_W:0] idx_r;
  logic cmp_vld_r;
  logic [1:0] hl_r;
  logic ev_valid_r, ev_wb_r;
  logic [31:0] ev_addr_r;

  logic o_valid_r, o_fetch_r, o_wnow_r, o_ev_valid_r, o_ev_wb_r;
  logic [1:0] o_hl_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [31:0] o_ev_addr_r;

  logic in_acc, issue, hit_now, last_cmp, out_free, prob_evict, over_prot, ev_seg;
  logic fin_seg, fin_dirty;
  logic ent_we;
  logic [SLOT_W-1:0] ent_wa, ent_ra;
  logic [TAG_W+2:0] ent_wd, ent_rd;
  logic ent_valid, ent_seg, ent_dirty;
  logic [TAG_W-1:0] ent_tag;
  list_cmd_t lcmd;
  list_sts_t lsts;

  // entry word: valid, segment, dirty, tag
  tsbc_ram #(.WIDTH(TAG_W + 3), .DEPTH(NSLOT)) u_entry (
    .clk, .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra), .rdata(ent_rd)
  );

  tsbc_lists u_lists (.clk, .rst_n, .cmd(lcmd), .sts(lsts));

  assign {ent_valid, ent_seg, ent_dirty, ent_tag} = ent_rd;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !o_valid_r || out_if.ready;
  assign issue    = (state_r == ST_SCAN) && !idx_r[SLOT_W];
  assign hit_now  = (state_r == ST_SCAN) && cmp_vld_r && ent_valid && (ent_tag == addr_r);
  assign last_cmp = cmp_vld_r && (cmp_idx_r == SLOT_W'(NSLOT - 1));
  assign prob_evict = (lsts.cnt[SEG_PROB] != '0)
                      && ({3'b000, lsts.cnt[SEG_PROB]} >= PROB_CAP_V);
  assign over_prot  = {3'b000, lsts.cnt[SEG_PROT]} > PROT_CAP_V;
  // victim segment when a miss must evict
  assign ev_seg = (prob_evict || lsts.cnt[SEG_PROB] != '0) ? SEG_PROB : SEG_PROT;
  // final segment and dirty bit of the requested entry
  assign fin_seg   = (op_r == OP_MISS) ? SEG_PROB : SEG_PROT;
  assign fin_dirty = (cmd_r == CMD_WRITE) ? !wt_r : ((op_r != OP_MISS) && hit_dirty_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:    if (clr_r == SLOT_W'(NSLOT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = bypass_r ? ST_FIN : ST_SCAN;
      ST_SCAN:   if (hit_now || last_cmp) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (hit_r || prob_evict || !free_found_r) state_nxt = ST_UNL_RD;
        else state_nxt = ST_FILL;
      end
      ST_UNL_RD: state_nxt = ST_UNL_WR;
      ST_UNL_WR: begin
        if (!evicting_r) state_nxt = ST_APP1;
        else if (op_r == OP_MISS) state_nxt = ST_FILL;
        else state_nxt = ST_FIN;
      end
      ST_FILL:   state_nxt = ST_APP1;
      ST_APP1:   state_nxt = ST_APP2;
      ST_APP2:   state_nxt = (op_r == OP_HPROB) ? ST_CHK : ST_FIN;
      ST_CHK:    state_nxt = over_prot ? ST_UNL_RD : ST_FIN;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_if.ready = 1'b0;
    ent_we      = 1'b0;
    ent_wa      = s_r;
    ent_wd      = {1'b1, fin_seg, fin_dirty, addr_r};
    ent_ra      = u_r;
    lcmd.op     = LOP_NONE;
    lcmd.slot   = s_r;
    lcmd.seg    = ap_seg_r;
    case (state_r)
      ST_CLR: begin
        ent_we = 1'b1; ent_wa = clr_r; ent_wd = '0;
      end
      ST_IDLE:   in_if.ready = 1'b1;
      ST_SCAN:   ent_ra = idx_r[SLOT_W-1:0];
      ST_UNL_RD: begin
        lcmd.op = LOP_RD; lcmd.slot = u_r;
      end
      ST_UNL_WR: begin
        lcmd.op = LOP_UNLINK; lcmd.slot = u_r; lcmd.seg = ent_seg;
        if (evicting_r) begin
          ent_we = 1'b1; ent_wa = u_r; ent_wd = {3'b000, ent_tag};
        end
      end
      ST_APP1:   lcmd.op = LOP_APP1;
      ST_APP2:   lcmd.op = LOP_APP2;
      ST_FIN:    ent_we = out_free && !byp_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      wt_r <= 1'b0; bypass_r <= 1'b0;
      o_valid_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + SLOT_W'(1);
      if (cfg_we) begin
        if (cfg_idx == CFG_WRITE_THROUGH) wt_r <= cfg_data;
        if (cfg_idx == CFG_BYPASS) bypass_r <= cfg_data;
      end
      if (state_r == ST_FIN && out_free) o_valid_r <= 1'b1;
      else if (out_if.ready) o_valid_r <= 1'b0;
      cmp_vld_r <= issue;
    end
  end

  // item payload and scan bookkeeping
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r[SLOT_W-1:0];
    case (state_r)
      ST_IDLE: begin
        cmd_r <= in_if.cmd;
        addr_r <= in_if.block_addr[TAG_W-1:0];
        byp_r <= bypass_r;
        idx_r <= '0;
        hit_r <= 1'b0;
        free_found_r <= 1'b0;
        evicting_r <= 1'b0;
        ev_valid_r <= 1'b0; ev_wb_r <= 1'b0; ev_addr_r <= '0;
        hl_r <= HIT_NONE;
        s_r <= '0;
      end
      ST_SCAN: begin
        if (issue) idx_r <= idx_r + 1'b1;
        if (cmp_vld_r && !ent_valid && !free_found_r) begin
          free_found_r <= 1'b1;
          fs_r <= cmp_idx_r;
        end
        if (hit_now) begin
          hit_r <= 1'b1;
          s_r <= cmp_idx_r;
          hit_seg_r <= ent_seg;
          hit_dirty_r <= ent_dirty;
        end
      end
      ST_DECIDE: begin
        if (hit_r) begin
          op_r <= (hit_seg_r == SEG_PROT) ? OP_HPROT : OP_HPROB;
          hl_r <= (hit_seg_r == SEG_PROT) ? HIT_PROT : HIT_PROB;
          u_r <= s_r;
          ap_seg_r <= SEG_PROT;
        end else begin
          op_r <= OP_MISS;
          ap_seg_r <= SEG_PROB;
          if (prob_evict || !free_found_r) begin
            evicting_r <= 1'b1;
            u_r <= lsts.head[ev_seg];
            s_r <= lsts.head[ev_seg];
          end else begin
            s_r <= fs_r;
          end
        end
      end
      ST_UNL_WR: if (evicting_r) begin
        ev_valid_r <= 1'b1;
        ev_addr_r <= 32'(ent_tag);
        ev_wb_r <= ent_dirty;
      end
      ST_CHK: if (over_prot) begin
        evicting_r <= 1'b1;
        u_r <= lsts.head[SEG_PROT];
        ap_seg_r <= SEG_PROT;
      end
      ST_FIN: if (out_free) begin
        o_hl_r <= byp_r ? HIT_NONE : hl_r;
        o_slot_r <= byp_r ? '0 : s_r;
        o_fetch_r <= (byp_r || op_r == OP_MISS) && (cmd_r == CMD_READ);
        o_wnow_r <= (cmd_r == CMD_WRITE) && (byp_r || wt_r);
        o_ev_valid_r <= !byp_r && ev_valid_r;
        o_ev_addr_r <= byp_r ? '0 : ev_addr_r;
        o_ev_wb_r <= !byp_r && ev_wb_r;
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid           = o_valid_r;
  assign out_if.hit_level       = o_hl_r;
  assign out_if.slot            = o_slot_r;
  assign out_if.fetch_needed    = o_fetch_r;
  assign out_if.write_now       = o_wnow_r;
  assign out_if.evict_valid     = o_ev_valid_r;
  assign out_if.evict_addr      = o_ev_addr_r;
  assign out_if.evict_writeback = o_ev_wb_r;
endmodule

// File: rtl/core/tsbc_chk.sv
// port-level checker for the block cache controller, bound to the top level
// depends on tsbc_pkg and assert_macros.svh
`include "assert_macros.svh"
module tsbc_chk import tsbc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_hit_level,
  input logic        out_fetch_needed,
  input logic        out_write_now,
  input logic        out_evict_valid,
  input logic        out_evict_writeback
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_wb_needs_evict, clk, rst_n, out_valid && out_evict_writeback, out_evict_valid)
  `ASSERT_IMPL(a_fetch_not_write, clk, rst_n, out_valid && out_fetch_needed, !out_write_now)
  `ASSERT_IMPL(a_prot_hit_no_evict, clk, rst_n, out_valid && out_hit_level == HIT_PROT,
               !out_evict_valid && !out_fetch_needed)
endmodule

bind two_segment_block_cache_policy tsbc_chk u_tsbc_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_hit_level(out_if.hit_level),
  .out_fetch_needed(out_if.fetch_needed),
  .out_write_now(out_if.write_now),
  .out_evict_valid(out_if.evict_valid),
  .out_evict_writeback(out_if.evict_writeback)
);

// File: tb/sv/tsbc_chan_if.sv
// the testbench drives the channel interfaces declared in rtl/core/tsbc_if.sv
// no declarations of its own

// File: tb/sv/two_segment_block_cache_policy_test.sv
// testbench of the segmented lru block cache controller: directed table, then random
// streams of reads and writes over small address pools, checked against a local predictor
// depends on tsbc_pkg, the channel interfaces and the rtl
module two_segment_block_cache_policy_test import tsbc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROT_CAP = 64;
  localparam int PROB_CAP = 64;

  typedef struct packed {
    logic [1:0]  hit_level;
    logic [6:0]  slot;
    logic        fetch_needed;
    logic        write_now;
    logic        evict_valid;
    logic [31:0] evict_addr;
    logic        evict_writeback;
  } verdict_t;

  typedef struct {
    logic        cmd;
    logic [31:0] addr;
    bit          typed;
    verdict_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic cfg_data = 1'b0;

  tsbc_in_if  req();
  tsbc_out_if rsp();

  two_segment_block_cache_policy dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_if(req.sink), .out_if(rsp.source)
  );

  always #2 clk = ~clk;

  // predictor copy of the tag and list state
  logic        wt_mode, byp_mode;
  logic [31:0] tag_q   [NSLOT];
  bit          valid_q [NSLOT];
  bit          seg_q   [NSLOT];
  bit          dirty_q [NSLOT];
  int          nxt_q   [NSLOT];
  int          prv_q   [NSLOT];
  int          head_q [2];
  int          tail_q [2];
  int          cnt_q  [2];

  verdict_t pending_verdicts[$];
  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 19, recv_idle = 88;
  bit  done = 0;

  initial begin
    req.valid = 1'b0;
    req.cmd = 1'b0;
    req.block_addr = '0;
    rsp.ready = 1'b0;
  end

  function automatic void clear_state();
    wt_mode = 0;
    byp_mode = 0;
    for (int i = 0; i < NSLOT; i++) begin
      valid_q[i] = 0; seg_q[i] = 0; dirty_q[i] = 0;
      tag_q[i] = '0; nxt_q[i] = 0; prv_q[i] = 0;
    end
    head_q = '{0, 0}; tail_q = '{0, 0}; cnt_q = '{0, 0};
  endfunction

  function automatic void list_remove(int s);
    int g, p, n;
    g = seg_q[s]; p = prv_q[s]; n = nxt_q[s];
    if (cnt_q[g] == 0) return;
    if (head_q[g] == s) head_q[g] = n; else nxt_q[p] = n;
    if (tail_q[g] == s) tail_q[g] = p; else prv_q[n] = p;
    cnt_q[g]--;
  endfunction

  function automatic void list_push(int g, int s);
    seg_q[s] = g;
    if (cnt_q[g] == 0) begin
      head_q[g] = s;
      prv_q[s] = s;
    end else begin
      nxt_q[tail_q[g]] = s;
      prv_q[s] = tail_q[g];
    end
    nxt_q[s] = s;
    tail_q[g] = s;
    cnt_q[g]++;
  endfunction

  function automatic int drop_head(int g, inout verdict_t v);
    int s;
    s = head_q[g];
    v.evict_valid = 1;
    v.evict_addr = tag_q[s];
    v.evict_writeback = dirty_q[s];
    list_remove(s);
    valid_q[s] = 0;
    dirty_q[s] = 0;
    return s;
  endfunction

  function automatic verdict_t cache_lookup(logic cmd, logic [31:0] addr);
    verdict_t v;
    int s;
    bit hit, found;
    v = '0; s = 0; hit = 0; found = 0;
    if (byp_mode) begin
      v.fetch_needed = (cmd == CMD_READ);
      v.write_now = (cmd == CMD_WRITE);
      return v;
    end
    for (int i = 0; i < NSLOT; i++)
      if (!hit && valid_q[i] && tag_q[i] == addr) begin
        s = i; hit = 1;
      end
    if (hit && seg_q[s] == SEG_PROT) begin
      v.hit_level = HIT_PROT;
      list_remove(s);
      list_push(SEG_PROT, s);
    end else if (hit) begin
      v.hit_level = HIT_PROB;
      list_remove(s);
      list_push(SEG_PROT, s);
      if (cnt_q[SEG_PROT] > PROT_CAP) void'(drop_head(SEG_PROT, v));
    end else begin
      if (cnt_q[SEG_PROB] > 0 && cnt_q[SEG_PROB] >= PROB_CAP) begin
        s = drop_head(SEG_PROB, v);
      end else begin
        for (int i = 0; i < NSLOT; i++)
          if (!found && !valid_q[i]) begin
            s = i; found = 1;
          end
        if (!found) s = drop_head(cnt_q[SEG_PROB] > 0 ? SEG_PROB : SEG_PROT, v);
      end
      tag_q[s] = addr;
      valid_q[s] = 1;
      dirty_q[s] = 0;
      list_push(SEG_PROB, s);
      v.fetch_needed = (cmd == CMD_READ);
    end
    if (cmd == CMD_WRITE) begin
      if (wt_mode) begin
        dirty_q[s] = 0;
        v.write_now = 1;
      end else begin
        dirty_q[s] = 1;
      end
    end
    v.slot = s[6:0];
    return v;
  endfunction

  // per-item typed expectations, consumed alongside predictor output
  verdict_t typed_verdicts[$];
  bit       typed_flags[$];

  // valid stays up after an accept until the next item or an idle cycle replaces it
  task automatic send_item(logic cmd, logic [31:0] addr, bit typed, verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.block_addr <= addr;
    do @(posedge clk); while (!req.ready);
    v = cache_lookup(cmd, addr);
    pending_verdicts.push_back(v);
    typed_flags.push_back(typed);
    typed_verdicts.push_back(want);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WRITE_THROUGH) wt_mode = val; else byp_mode = val;
    @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    verdict_t got, exp, want;
    bit typed;
    if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.hit_level, rsp.slot, rsp.fetch_needed, rsp.write_now,
                rsp.evict_valid, rsp.evict_addr, rsp.evict_writeback};
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          errors++;
        end else begin
          exp = pending_verdicts.pop_front();
          typed = typed_flags.pop_front();
          want = typed_verdicts.pop_front();
          if (typed && want != exp) begin
            $display("%0t: table row disagrees: expected %h, predicted %h", $realtime,
                     want, exp);
            errors++;
          end
          if (got.hit_level != exp.hit_level || got.slot != exp.slot ||
              got.fetch_needed != exp.fetch_needed || got.write_now != exp.write_now ||
              got.evict_valid != exp.evict_valid || got.evict_addr != exp.evict_addr ||
              got.evict_writeback != exp.evict_writeback) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, exp, got);
            errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2_000_000 && !done) begin
      $display("two_segment_block_cache_policy verification failed");
      $finish;
    end
  end

  function automatic verdict_t mk(logic [1:0] hl, int s, logic f, logic w);
    verdict_t v;
    v = '0;
    v.hit_level = hl; v.slot = s[6:0]; v.fetch_needed = f; v.write_now = w;
    return v;
  endfunction

  initial begin
    row_t table_rows[$];
    logic [31:0] pool[$];
    int n, burst;
    logic [31:0] a;

    clear_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows after reset, default registers
    table_rows = '{
      '{CMD_READ,  32'h0000_0000, 1, mk(HIT_NONE, 0, 1, 0)},
      '{CMD_WRITE, 32'hFFFF_FFFF, 1, mk(HIT_NONE, 1, 0, 0)},
      '{CMD_READ,  32'h0000_0000, 1, mk(HIT_PROB, 0, 0, 0)},
      '{CMD_READ,  32'h0000_0000, 1, mk(HIT_PROT, 0, 0, 0)},
      '{CMD_WRITE, 32'hFFFF_FFFF, 1, mk(HIT_PROB, 1, 0, 0)},
      '{CMD_WRITE, 32'hFFFF_FFFF, 0, '0},
      '{CMD_READ,  32'hAAAA_5555, 0, '0},
      '{CMD_WRITE, 32'h5555_AAAA, 0, '0},
      '{CMD_WRITE, 32'hAAAA_5555, 0, '0}
    };
    foreach (table_rows[i])
      send_item(table_rows[i].cmd, table_rows[i].addr, table_rows[i].typed,
                table_rows[i].want);
    wait_drained();

    write_reg(CFG_WRITE_THROUGH, 1'b1);
    send_item(CMD_WRITE, 32'h0000_0000, 1, mk(HIT_PROT, 0, 0, 1));
    send_item(CMD_WRITE, 32'h8000_0001, 1, mk(HIT_NONE, 4, 0, 1));
    send_item(CMD_READ,  32'h5555_AAAA, 0, '0);
    wait_drained();
    write_reg(CFG_BYPASS, 1'b1);
    send_item(CMD_READ,  32'h0000_0000, 1, mk(HIT_NONE, 0, 1, 0));
    send_item(CMD_WRITE, 32'h1234_5678, 1, mk(HIT_NONE, 0, 0, 1));
    wait_drained();
    write_reg(CFG_BYPASS, 1'b0);
    write_reg(CFG_WRITE_THROUGH, 1'b0);

    // random part: address pools sized around the capacities force evictions
    n = 0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 88; recv_idle = 19; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      while (n < 530 * (ph + 1)) begin
        wait_drained();
        write_reg(CFG_WRITE_THROUGH, $urandom_range(3) == 0);
        write_reg(CFG_BYPASS, $urandom_range(7) == 0);
        pool.delete();
        repeat ($urandom_range(40, 180)) begin
          a = $urandom();
          if ($urandom_range(3) == 0) a = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3)
                                                            : $urandom_range(3);
          pool.push_back(a);
        end
        burst = $urandom_range(60, 140);
        repeat (burst) begin
          // mostly reuse recent hot addresses so both lists fill and churn
          if ($urandom_range(9) == 0) a = $urandom();
          else if ($urandom_range(1)) a = pool[$urandom_range(pool.size() > 20 ? 19 : 0)];
          else a = pool[$urandom_range(pool.size() - 1)];
          send_item($urandom_range(1), a, 0, '0);
          n++;
        end
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    done = 1;
    if (errors == 0 && pending_verdicts.size() == 0)
      $display("two_segment_block_cache_policy verification clean");
    else
      $display("two_segment_block_cache_policy verification failed");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tsbc_pkg.sv
rtl/core/tsbc_if.sv
rtl/core/tsbc_ram.sv
rtl/core/tsbc_lists.sv
rtl/core/two_segment_block_cache_policy.sv
rtl/core/tsbc_chk.sv
tb/sv/tsbc_chan_if.sv
tb/sv/two_segment_block_cache_policy_test.sv
